[src/mandelbrot_pixel_escape_color_macros.svh]
// assertion macros shared by the escape-time block
`ifndef MANDELBROT_PIXEL_ESCAPE_COLOR_MACROS_SVH
`define MANDELBROT_PIXEL_ESCAPE_COLOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MPEC_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MPEC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPEC_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg)
`define MPEC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

[src/mpec_pkg.sv]
// types, constants and helpers of the escape-time pixel block
package mpec_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int ITER_MAX      = 1023;

  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;
  localparam int DIVIDEND_W = 44;
  localparam int DIVISOR_W  = 13;

  localparam int BANDS      = 5;
  localparam int BAND_RECIP = 205;
  localparam int BAND_SHIFT = 10;

  localparam logic [2:0] REG_CENTER_RE     = 3'd0;
  localparam logic [2:0] REG_CENTER_IM     = 3'd1;
  localparam logic [2:0] REG_PLANE_WIDTH   = 3'd2;
  localparam logic [2:0] REG_PLANE_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [2:0] REG_MAX_ITER      = 3'd6;

  typedef struct packed {
    logic signed [31:0] center_re;
    logic signed [31:0] center_im;
    logic [30:0]        plane_width;
    logic [30:0]        plane_height;
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
    logic [9:0]         max_iterations;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_re:      32'sd0,
    center_im:      32'sd0,
    plane_width:    31'd1073741824,
    plane_height:   31'd1073741824,
    screen_width:   13'd1024,
    screen_height:  13'd1024,
    max_iterations: 10'd64
  };

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic signed [31:0] coord_re;
    logic signed [31:0] coord_im;
    logic [9:0]         iter_count;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } res_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [2:0] {
    BAND_DEEP   = 3'd0,
    BAND_VIOLET = 3'd1,
    BAND_ROSE   = 3'd2,
    BAND_PEACH  = 3'd3,
    BAND_PALE   = 3'd4
  } band_t;

  localparam rgb_t PALETTE [BANDS] = '{
    '{red: 8'd75,  green: 8'd75,  blue: 8'd165},
    '{red: 8'd154, green: 8'd92,  blue: 8'd175},
    '{red: 8'd224, green: 8'd118, blue: 8'd158},
    '{red: 8'd250, green: 8'd190, blue: 8'd140},
    '{red: 8'd252, green: 8'd255, blue: 8'd148}
  };

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // clamp a wide signed sum to the 32-bit coordinate range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

[src/mpec_regs.sv]
// configuration register file behind the apb port
module mpec_regs
  import mpec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_CENTER_RE:     cfg.center_re      <= pwdata;
        REG_CENTER_IM:     cfg.center_im      <= pwdata;
        REG_PLANE_WIDTH:   cfg.plane_width    <= pwdata[30:0];
        REG_PLANE_HEIGHT:  cfg.plane_height   <= pwdata[30:0];
        REG_SCREEN_WIDTH:  cfg.screen_width   <= pwdata[12:0];
        REG_SCREEN_HEIGHT: cfg.screen_height  <= pwdata[12:0];
        REG_MAX_ITER:      cfg.max_iterations <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_RE:     prdata = cfg.center_re;
      REG_CENTER_IM:     prdata = cfg.center_im;
      REG_PLANE_WIDTH:   prdata = {1'b0, cfg.plane_width};
      REG_PLANE_HEIGHT:  prdata = {1'b0, cfg.plane_height};
      REG_SCREEN_WIDTH:  prdata = {19'd0, cfg.screen_width};
      REG_SCREEN_HEIGHT: prdata = {19'd0, cfg.screen_height};
      REG_MAX_ITER:      prdata = {22'd0, cfg.max_iterations};
      default:           prdata = '0;
    endcase
  end

endmodule

[src/mpec_div.sv]
// serial restoring divider, one quotient bit per cycle
module mpec_div
  import mpec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output div_status_t           status
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // shift the next dividend bit into the partial remainder
  assign trial    = {rem, quo[DIVIDEND_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= CNT_W'(DIVIDEND_W - 1);
      end else if (status.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (status.busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];
    end
  end

endmodule

[src/mpec_palette.sv]
// colour band lookup from iteration count and limit
module mpec_palette
  import mpec_pkg::*;
(
  input  logic [9:0] count,
  input  logic [9:0] limit,
  output rgb_t       rgb
);

  logic [17:0] recip_prod;
  logic [7:0]  band;
  logic [10:0] cnt_w;
  logic [10:0] t1;
  logic [10:0] t2;
  logic [10:0] t3;
  logic [10:0] t4;
  band_t       sel;

  // limit / 5 as a reciprocal multiply, exact for ten-bit limits
  assign recip_prod = 18'(limit) * 18'(BAND_RECIP);
  assign band       = 8'(recip_prod >> BAND_SHIFT);
  assign cnt_w      = 11'(count);
  assign t1         = 11'(band);
  assign t2         = 11'(band) << 1;
  assign t3         = 11'(band) * 11'd3;
  assign t4         = 11'(band) << 2;

  always_comb begin
    priority if (cnt_w < t1) begin
      sel = BAND_DEEP;
    end else if (cnt_w < t2) begin
      sel = BAND_VIOLET;
    end else if (cnt_w < t3) begin
      sel = BAND_ROSE;
    end else if (cnt_w < t4) begin
      sel = BAND_PEACH;
    end else begin
      sel = BAND_PALE;
    end
  end

  assign rgb = PALETTE[sel];

endmodule

[src/mandelbrot_pixel_escape_color.sv]
// escape-time pixel evaluator: sequencer around one shared 32x32 multiplier
//
//   port group   role     handshake            payload
//   pix          input    pix_valid/pix_ready  pixel_x, pixel_y
//   res          output   res_valid/res_ready  coord_re, coord_im, iter_count, rgb
//   apb          config   psel/penable/pwrite  7 registers at 4*i, pready tied high
//
// a pixel first maps the point with two runs of the serial divider, one per 44-bit quotient,
// then each iteration steps through four states (a*a, b*b, a*b, update), the first three
// of them on the single multiplier
// the result register frees the core, so the next pixel is taken while a result waits
// a stalled result holds the core in its final state until the register frees up
// reset returns the configuration registers to their defaults; no memory, no clearing pass
`include "mandelbrot_pixel_escape_color_macros.svh"
module mandelbrot_pixel_escape_color
  import mpec_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  pix_t              pix,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic signed [65:0] ESCAPE = 66'sd4 <<< FRAC_BITS;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_MULX      = 12'b000000000010,
    S_DIVX_GO   = 12'b000000000100,
    S_DIVX_WAIT = 12'b000000001000,
    S_MULY      = 12'b000000010000,
    S_DIVY_GO   = 12'b000000100000,
    S_DIVY_WAIT = 12'b000001000000,
    S_ITER_AA   = 12'b000010000000,
    S_ITER_BB   = 12'b000100000000,
    S_ITER_AB   = 12'b001000000000,
    S_ITER_UPD  = 12'b010000000000,
    S_DONE      = 12'b100000000000
  } state_t;

  state_t state;

  cfg_t        cfg;
  div_status_t div_stat;
  rgb_t        rgb;

  logic [11:0]        px;
  logic [11:0]        py;
  logic [9:0]         limit;
  logic [9:0]         count;
  logic               neg;
  logic signed [31:0] cr;
  logic signed [31:0] ci;
  logic signed [31:0] a;
  logic signed [31:0] b;
  logic signed [63:0] aa;
  logic signed [63:0] bb;
  logic signed [63:0] prod;

  logic [12:0]           sw_eff;
  logic [12:0]           sh_eff;
  logic                  y_neg;
  logic [12:0]           mag;
  logic signed [31:0]    mul_a;
  logic signed [31:0]    mul_b;
  logic                  div_start;
  logic [DIVISOR_W-1:0]  div_dvs;
  logic [DIVIDEND_W-1:0] div_q;
  logic signed [65:0]    q66;
  logic signed [65:0]    map_re;
  logic signed [65:0]    map_im;
  logic signed [63:0]    ab;
  logic signed [65:0]    esc_sum;
  logic signed [65:0]    a_sum;
  logic signed [65:0]    b_sum;
  logic                  res_free;

  mpec_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DIVIDEND_W-1:0]),
    .divisor  (div_dvs),
    .quotient (div_q),
    .status   (div_stat)
  );

  mpec_palette u_palette (
    .count (count),
    .limit (limit),
    .rgb   (rgb)
  );

  // a zero screen size counts as one pixel
  assign sw_eff = (cfg.screen_width == '0) ? 13'd1 : cfg.screen_width;
  assign sh_eff = (cfg.screen_height == '0) ? 13'd1 : cfg.screen_height;

  // rows below the screen give a negative offset, divided toward zero
  assign y_neg = {1'b0, py} > sh_eff;
  assign mag   = y_neg ? ({1'b0, py} - sh_eff) : (sh_eff - {1'b0, py});

  assign div_start = (state == S_DIVX_GO) || (state == S_DIVY_GO);
  assign div_dvs   = (state == S_DIVX_GO) ? sw_eff : sh_eff;

  always_comb begin
    unique case (state)
      S_MULX: begin
        mul_a = $signed({20'd0, px});
        mul_b = $signed({1'b0, cfg.plane_width});
      end
      S_MULY: begin
        mul_a = $signed({19'd0, mag});
        mul_b = $signed({1'b0, cfg.plane_height});
      end
      S_ITER_AA: begin
        mul_a = a;
        mul_b = a;
      end
      S_ITER_BB: begin
        mul_a = b;
        mul_b = b;
      end
      S_ITER_AB: begin
        mul_a = a;
        mul_b = b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // the shared multiplier, registered straight away
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign q66    = $signed({22'd0, div_q});
  assign map_re = 66'(cfg.center_re) - $signed({36'd0, cfg.plane_width[30:1]}) + q66;
  assign map_im = 66'(cfg.center_im) - $signed({36'd0, cfg.plane_height[30:1]})
                  + (neg ? -q66 : q66);

  assign ab      = prod >>> (FRAC_BITS - 1);
  assign esc_sum = 66'(aa) + 66'(bb);
  assign a_sum   = 66'(aa) - 66'(bb) + 66'(cr);
  assign b_sum   = 66'(ab) + 66'(ci);

  assign res_free  = !res_valid || res_ready;
  assign pix_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      limit     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pix_valid) begin
            limit <= (int'(cfg.max_iterations) < ITER_MAX) ? cfg.max_iterations
                                                            : 10'(ITER_MAX);
            state <= S_MULX;
          end
        end
        S_MULX:      state <= S_DIVX_GO;
        S_DIVX_GO:   state <= S_DIVX_WAIT;
        S_DIVX_WAIT: begin
          if (div_stat.done) begin
            state <= S_MULY;
          end
        end
        S_MULY:      state <= S_DIVY_GO;
        S_DIVY_GO:   state <= S_DIVY_WAIT;
        S_DIVY_WAIT: begin
          if (div_stat.done) begin
            count <= '0;
            state <= S_ITER_AA;
          end
        end
        S_ITER_AA: begin
          state <= (count >= limit) ? S_DONE : S_ITER_BB;
        end
        S_ITER_BB:   state <= S_ITER_AB;
        S_ITER_AB:   state <= S_ITER_UPD;
        S_ITER_UPD: begin
          if (esc_sum >= ESCAPE) begin
            state <= S_DONE;
          end else begin
            count <= count + 1'b1;
            state <= S_ITER_AA;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register handshake, loaded as the finished pixel leaves the core
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && res_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (pix_valid) begin
          px <= pix.pixel_x;
          py <= pix.pixel_y;
        end
      end
      S_MULY: neg <= y_neg;
      S_DIVX_WAIT: begin
        if (div_stat.done) begin
          cr <= sat32(map_re);
        end
      end
      S_DIVY_WAIT: begin
        if (div_stat.done) begin
          ci <= sat32(map_im);
          a  <= '0;
          b  <= '0;
        end
      end
      S_ITER_BB: aa <= prod >>> FRAC_BITS;
      S_ITER_AB: bb <= prod >>> FRAC_BITS;
      S_ITER_UPD: begin
        a <= sat32(a_sum);
        b <= sat32(b_sum);
      end
      S_DONE: begin
        if (res_free) begin
          res.coord_re   <= cr;
          res.coord_im   <= ci;
          res.iter_count <= count;
          res.red        <= rgb.red;
          res.green      <= rgb.green;
          res.blue       <= rgb.blue;
        end
      end
      default: begin
      end
    endcase
  end

  `MPEC_ASSERT_SAME(a_count_limit, clk, rst, state == S_ITER_AA, count <= limit,
                    "iteration count passed the limit")
  `MPEC_ASSERT_SAME(a_div_done, clk, rst, div_stat.done,
                    state == S_DIVX_WAIT || state == S_DIVY_WAIT,
                    "divider finished outside a wait state")
  `MPEC_ASSERT_SAME(a_div_idle, clk, rst, div_start, !div_stat.busy,
                    "divider started while busy")
  `MPEC_ASSERT_NEXT(a_res_load, clk, rst, state == S_DONE && res_free,
                    res_valid && state == S_IDLE,
                    "finished pixel not moved to the result register")

endmodule

[verif/tb_top.sv]
// testbench for the mandelbrot escape-time pixel block: directed table, random views, scoreboard
`timescale 1ns / 100ps
module tb_top;
  import mpec_pkg::*;

  localparam int FRAC = 28;
  localparam longint ESCAPE_SQ = longint'(4) << FRAC;
  localparam longint TOP32 = 64'sd2147483647;
  localparam longint BOTTOM32 = -64'sd2147483648;
  localparam int LIMIT_CAP = 1023;
  localparam int SHADE_COUNT = 5;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 62;
  localparam int DEEP_ITEMS = 12;
  localparam int SMALL_LIMIT_PHASE = 2;
  localparam int PAUSE_PHASE = 3;
  localparam int DEEP_PHASE = 5;
  localparam int PLAN_LEN = 30;

  localparam rgb_t SHADES [SHADE_COUNT] = '{
    '{8'd75, 8'd75, 8'd165},
    '{8'd154, 8'd92, 8'd175},
    '{8'd224, 8'd118, 8'd158},
    '{8'd250, 8'd190, 8'd140},
    '{8'd252, 8'd255, 8'd148}
  };

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    pix_t        p;
    bit          known;
    logic [9:0]  cnt;
    band_t       shade;
  } row_t;

  // known rows carry the count and band; coordinates always come from the predictor
  row_t plan [PLAN_LEN] = '{
    // reset view: corner (-2,+2) escapes after one step, origin never escapes
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd0, 12'd0}, 1'b1, 10'd1, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd512, 12'd512}, 1'b1, 10'd64, BAND_PALE},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd4095, 12'd4095}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd4095, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd0, 12'd4095}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd700, 12'd300}, 1'b0, 10'd0, BAND_DEEP},
    // limit of zero, then a limit below five: zero band width, always the last band
    '{ROW_WRITE, REG_MAX_ITER, 32'd0, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd512, 12'd512}, 1'b1, 10'd0, BAND_PALE},
    '{ROW_WRITE, REG_MAX_ITER, 32'd3, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd512, 12'd512}, 1'b1, 10'd3, BAND_PALE},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd0, 12'd0}, 1'b1, 10'd1, BAND_PALE},
    // zero screen size counts as one pixel, pixels past it extrapolate
    '{ROW_WRITE, REG_SCREEN_WIDTH, 32'd0, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_SCREEN_HEIGHT, 32'd0, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_MAX_ITER, 32'd1023, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd0, 12'd0}, 1'b1, 10'd1, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd1, 12'd1}, 1'b1, 10'd1, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd4095, 12'd4095}, 1'b0, 10'd0, BAND_DEEP},
    // extreme view, mapped point saturates
    '{ROW_WRITE, REG_CENTER_RE, 32'h7FFF_FFFF, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_CENTER_IM, 32'h8000_0000, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_PLANE_WIDTH, 32'h7FFF_FFFF, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_PLANE_HEIGHT, 32'hFFFF_FFFF, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_SCREEN_WIDTH, 32'd8191, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_SCREEN_HEIGHT, 32'd4096, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd4095, 12'd4095}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    // collapsed view on the origin runs the full limit
    '{ROW_WRITE, REG_CENTER_RE, 32'h0, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_CENTER_IM, 32'h0, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_PLANE_WIDTH, 32'h0, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_WRITE, REG_PLANE_HEIGHT, 32'h0, '{12'd0, 12'd0}, 1'b0, 10'd0, BAND_DEEP},
    '{ROW_PIXEL, REG_CENTER_RE, 32'h0, '{12'd123, 12'd456}, 1'b1, 10'd1023, BAND_PALE}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              pix_valid;
  logic              pix_ready;
  pix_t              pix;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cfg_t view_cfg;
  res_t pending_pixels [$];
  res_t oldest;
  int   errors = 0;
  int   results_seen = 0;
  int   cycles = 0;
  bit   no_idle = 1'b0;
  bit   long_hold_done = 1'b0;

  mandelbrot_pixel_escape_color u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  function automatic longint clip32(longint v);
    if (v > TOP32) return TOP32;
    if (v < BOTTOM32) return BOTTOM32;
    return v;
  endfunction

  // maps the pixel, runs the escape loop and picks the band for the current view
  function automatic res_t predict_escape(pix_t p);
    longint sw, sh, pw, ph, cre, cim, px, py, cr, ci;
    longint a, b, aa, bb, ab, lim, cnt, bw;
    band_t  shade;
    res_t   r;
    sw = view_cfg.screen_width;
    sh = view_cfg.screen_height;
    if (sw == 0) sw = 1;
    if (sh == 0) sh = 1;
    pw = view_cfg.plane_width;
    ph = view_cfg.plane_height;
    cre = view_cfg.center_re;
    cim = view_cfg.center_im;
    px = p.pixel_x;
    py = p.pixel_y;
    cr = clip32(cre - (pw >>> 1) + (px * pw) / sw);
    // imaginary axis flipped, division truncates toward zero
    ci = clip32(cim - (ph >>> 1) + ((sh - py) * ph) / sh);
    lim = view_cfg.max_iterations;
    if (lim > LIMIT_CAP) lim = LIMIT_CAP;
    a = 0;
    b = 0;
    cnt = 0;
    while (cnt < lim) begin
      aa = (a * a) >>> FRAC;
      bb = (b * b) >>> FRAC;
      if (aa + bb >= ESCAPE_SQ) break;
      ab = (a * b) >>> (FRAC - 1);
      a = clip32(aa - bb + cr);
      b = clip32(ab + ci);
      cnt++;
    end
    bw = lim / SHADE_COUNT;
    if (cnt < bw) begin
      shade = BAND_DEEP;
    end else if (cnt < 2 * bw) begin
      shade = BAND_VIOLET;
    end else if (cnt < 3 * bw) begin
      shade = BAND_ROSE;
    end else if (cnt < 4 * bw) begin
      shade = BAND_PEACH;
    end else begin
      shade = BAND_PALE;
    end
    r.coord_re = cr[31:0];
    r.coord_im = ci[31:0];
    r.iter_count = cnt[9:0];
    {r.red, r.green, r.blue} = SHADES[shade];
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_wait();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 160);
  endfunction

  task automatic check_field(string fld, logic signed [63:0] w, logic signed [63:0] g);
    if (g !== w) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, fld, w, g);
      errors++;
    end
  endtask

  task automatic wait_for_results();
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CENTER_RE:     view_cfg.center_re = val;
      REG_CENTER_IM:     view_cfg.center_im = val;
      REG_PLANE_WIDTH:   view_cfg.plane_width = val[30:0];
      REG_PLANE_HEIGHT:  view_cfg.plane_height = val[30:0];
      REG_SCREEN_WIDTH:  view_cfg.screen_width = val[12:0];
      REG_SCREEN_HEIGHT: view_cfg.screen_height = val[12:0];
      REG_MAX_ITER:      view_cfg.max_iterations = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(pix_t p, res_t want);
    int gap;
    gap = no_idle ? 0 : pick_wait();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix <= p;
    pix_valid <= 1'b1;
    do @(posedge clk); while (!pix_ready);
    pending_pixels.push_back(want);
    @(negedge clk);
  endtask

  // result side: random stalls plus one long hold to back the block up
  initial begin
    int stall;
    stall = 0;
    res_ready = 1'b0;
    wait (!rst);
    forever begin
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        res_ready <= 1'b0;
        stall--;
        @(negedge clk);
      end else begin
        res_ready <= 1'b1;
        stall = no_idle ? 0 : pick_wait();
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: result transfer with nothing expected, iter_count %0d", $time,
                 res.iter_count);
        errors++;
      end else begin
        oldest = pending_pixels.pop_front();
        results_seen++;
        check_field("coord_re", oldest.coord_re, res.coord_re);
        check_field("coord_im", oldest.coord_im, res.coord_im);
        check_field("iter_count", oldest.iter_count, res.iter_count);
        check_field("red", oldest.red, res.red);
        check_field("green", oldest.green, res.green);
        check_field("blue", oldest.blue, res.blue);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t        row;
    res_t        want;
    pix_t        p;
    logic [31:0] v;
    int          roll;
    int          items;
    int          span_x;
    int          span_y;
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    view_cfg = '{32'sd0, 32'sd0, 31'd1073741824, 31'd1073741824, 13'd1024, 13'd1024, 10'd64};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        pix_valid <= 1'b0;
        wait_for_results();
        write_reg(row.reg_idx, row.value);
      end else begin
        want = predict_escape(row.p);
        if (row.known) begin
          want.iter_count = row.cnt;
          {want.red, want.green, want.blue} = SHADES[row.shade];
        end
        send_pixel(row.p, want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      pix_valid <= 1'b0;
      no_idle = (ph == 1 || ph == 6);
      wait_for_results();
      for (int k = REG_CENTER_RE; k <= REG_MAX_ITER; k++) begin
        roll = $urandom_range(0, 99);
        // mostly views around the set, now and then anything at all
        case (3'(k))
          REG_CENTER_RE: begin
            v = (roll < 80) ? $urandom_range(0, 32'h3000_0000) - 32'h2000_0000 : $urandom();
          end
          REG_CENTER_IM: begin
            v = (roll < 80) ? $urandom_range(0, 32'h3000_0000) - 32'h1800_0000 : $urandom();
          end
          REG_PLANE_WIDTH, REG_PLANE_HEIGHT: begin
            v = (roll < 80) ? $urandom_range(32'h0040_0000, 32'h3000_0000) : $urandom();
          end
          REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT: begin
            if (roll < 75) begin
              v = $urandom_range(1, 200);
            end else if (roll < 85) begin
              v = 0;
            end else begin
              v = $urandom_range(0, 8191);
            end
          end
          default: begin
            if (ph == SMALL_LIMIT_PHASE) begin
              v = $urandom_range(0, 4);
            end else if (ph == DEEP_PHASE) begin
              v = $urandom_range(900, 1023);
            end else begin
              v = (roll < 85) ? $urandom_range(5, 120) : $urandom_range(5, 255);
            end
          end
        endcase
        write_reg(3'(k), v);
      end

      items = (ph == DEEP_PHASE) ? DEEP_ITEMS : PHASE_ITEMS;
      span_x = (view_cfg.screen_width == 0) ? 1 :
               (view_cfg.screen_width > 4096) ? 4096 : view_cfg.screen_width;
      span_y = (view_cfg.screen_height == 0) ? 1 :
               (view_cfg.screen_height > 4096) ? 4096 : view_cfg.screen_height;
      for (int n = 0; n < items; n++) begin
        // let the block run dry once in the middle of a phase
        if (ph == PAUSE_PHASE && n == items / 2) begin
          pix_valid <= 1'b0;
          @(negedge clk);
          wait_for_results();
        end
        if ($urandom_range(0, 3) != 0) begin
          p.pixel_x = 12'($urandom_range(0, span_x - 1));
          p.pixel_y = 12'($urandom_range(0, span_y - 1));
        end else begin
          p.pixel_x = 12'($urandom());
          p.pixel_y = 12'($urandom());
        end
        send_pixel(p, predict_escape(p));
      end
    end

    pix_valid <= 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/mpec_pkg.sv
src/mpec_regs.sv
src/mpec_div.sv
src/mpec_palette.sv
src/mandelbrot_pixel_escape_color.sv
verif/tb_top.sv
